[rtl/fqrv_pkg.sv]
// shared types and command codes for the fifo queue with remove by value
package fqrv_pkg;

	localparam logic [1:0] CMD_QUERY   = 2'd0;
	localparam logic [1:0] CMD_ENQUEUE = 2'd1;
	localparam logic [1:0] CMD_DEQUEUE = 2'd2;
	localparam logic [1:0] CMD_REMOVE  = 2'd3;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic   enq;
		logic   deq;
		logic   rem;
		value_t val;
	} cell_ctrl_t;

endpackage

[rtl/fqrv_cmd_if.sv]
// command channel interface: command and value per transaction
interface fqrv_cmd_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  cmd;
	logic signed [31:0] value_in;

	modport source (output valid, output cmd, output value_in, input ready);
	modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

[rtl/fqrv_rsp_if.sv]
// result channel interface: status and queue view per transaction
interface fqrv_rsp_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic signed [31:0] out_value;
	logic signed [31:0] head_value;
	logic signed [31:0] tail_value;
	logic               is_empty;
	logic        [4:0]  entry_count;

	modport source (output valid, output ok, output out_value, output head_value,
		output tail_value, output is_empty, output entry_count, input ready);
	modport sink   (input valid, input ok, input out_value, input head_value,
		input tail_value, input is_empty, input entry_count, output ready);
endinterface

[rtl/fqrv_cell.sv]
// one queue slot: holds an entry, compares it, shifts toward the head
module fqrv_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                  clk,
	input  fqrv_pkg::cell_ctrl_t  ctl,
	input  logic [CW-1:0]         count,
	input  fqrv_pkg::value_t      next_data,
	input  logic                  match_in,
	output logic                  match_out,
	output fqrv_pkg::value_t      data,
	output fqrv_pkg::value_t      tail
);
	import fqrv_pkg::*;

	localparam logic [CW:0] IDX_W  = (CW+1)'(IDX);
	localparam logic [CW:0] IDX_P1 = (CW+1)'(IDX + 1);

	value_t      data_q;
	logic [CW:0] count_w;
	logic        live;
	logic        hit;

	assign count_w   = {1'b0, count};
	assign live      = IDX_W < count_w;
	assign hit       = live && (data_q == ctl.val);
	assign match_out = match_in || hit;
	assign data      = data_q;
	assign tail      = (IDX_P1 == count_w) ? data_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.enq && (count_w == IDX_W)) begin
			data_q <= ctl.val;
		end else if (ctl.deq || (ctl.rem && match_out)) begin
			data_q <= next_data;
		end
	end
endmodule

[rtl/fifo_queue_remove_by_value_core.sv]
// top level of the fifo queue with remove by value
//
// bounded queue of signed 32-bit entries built as a row of slot cells,
// head in the first cell; every cell compares its entry in parallel and
// removal shifts the cells behind the first match one place forward
// channels: cmd_ch (sink) takes cmd and value_in; rsp_ch (source) gives
// ok, out_value, head_value, tail_value, is_empty and entry_count
// commands: query, enqueue at tail, dequeue from head, remove first match
// the result passes through pend_q into the result register; rsp_ch.valid
// rises once that register is loaded
// a new command waits for the last result to load; the cells update on the
// accept edge, the result is read out of the updated cells in the next one
// while the result register is loaded, no command is taken
// a new command is taken in the cycle a held result is taken
// stall: a result holds in rsp_ch until taken; cmd_ch.ready stays low
// while a result waits and is not being taken
// reset: queue empties, no result pending; entry data is not cleared
module fifo_queue_remove_by_value_core #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	fqrv_cmd_if.sink    cmd_ch,
	fqrv_rsp_if.source  rsp_ch
);
	import fqrv_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          pend_q;
	logic          ok_q;
	value_t        taken_q;
	logic          out_valid_q;
	logic          out_ok_q;
	value_t        out_value_q;
	value_t        head_q;
	value_t        tail_q;
	logic          empty_q;
	logic [4:0]    out_count_q;

	cell_ctrl_t    ctl;
	logic          accept;
	logic          rsp_done;
	logic          full;
	logic          empty;
	logic          found;
	logic          ok_n;
	logic [CW-1:0] count_n;
	value_t        tail_all;
	logic [CW+4:0] count_ext;

	value_t        cell_data [DEPTH];
	value_t        cell_tail [DEPTH];
	logic          match     [DEPTH+1];

	assign cmd_ch.ready = !pend_q && (!out_valid_q || rsp_ch.ready);
	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign rsp_done     = rsp_ch.valid && rsp_ch.ready;
	assign full         = count_q == CW'(DEPTH);
	assign empty        = count_q == '0;
	assign found        = match[DEPTH];

	assign ctl.enq = accept && (cmd_ch.cmd == CMD_ENQUEUE) && !full;
	assign ctl.deq = accept && (cmd_ch.cmd == CMD_DEQUEUE) && !empty;
	assign ctl.rem = accept && (cmd_ch.cmd == CMD_REMOVE);
	assign ctl.val = cmd_ch.value_in;

	assign match[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			value_t nxt;
			if (gi < DEPTH - 1) begin : g_mid
				assign nxt = cell_data[gi+1];
			end else begin : g_last
				assign nxt = cell_data[gi];
			end
			fqrv_cell #(
				.IDX (gi),
				.CW  (CW)
			) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.count     (count_q),
				.next_data (nxt),
				.match_in  (match[gi]),
				.match_out (match[gi+1]),
				.data      (cell_data[gi]),
				.tail      (cell_tail[gi])
			);
		end
	endgenerate

	always_comb begin
		tail_all = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_all = tail_all | cell_tail[i];
		end
	end

	always_comb begin
		ok_n    = 1'b0;
		count_n = count_q;
		unique case (cmd_ch.cmd)
			CMD_QUERY: begin
				ok_n = 1'b1;
			end
			CMD_ENQUEUE: begin
				ok_n = !full;
				if (!full) count_n = count_q + 1'b1;
			end
			CMD_DEQUEUE: begin
				ok_n = !empty;
				if (!empty) count_n = count_q - 1'b1;
			end
			CMD_REMOVE: begin
				ok_n = found;
				if (found) count_n = count_q - 1'b1;
			end
			default: begin
				ok_n = 1'b0;
			end
		endcase
	end

	assign count_ext = {5'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_n;
			end
			pend_q <= accept;
			if (pend_q) begin
				out_valid_q <= 1'b1;
			end else if (rsp_done) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= ok_n;
			taken_q <= ctl.deq ? cell_data[0] : '0;
		end
		if (pend_q) begin
			out_ok_q    <= ok_q;
			out_value_q <= taken_q;
			head_q      <= empty ? '0 : cell_data[0];
			tail_q      <= tail_all;
			empty_q     <= empty;
			out_count_q <= count_ext[4:0];
		end
	end

	assign rsp_ch.valid       = out_valid_q;
	assign rsp_ch.ok          = out_ok_q;
	assign rsp_ch.out_value   = out_value_q;
	assign rsp_ch.head_value  = head_q;
	assign rsp_ch.tail_value  = tail_q;
	assign rsp_ch.is_empty    = empty_q;
	assign rsp_ch.entry_count = out_count_q;
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for the fifo queue with remove by value
module testbench;
	import fqrv_pkg::*;

	localparam int QUEUE_DEPTH = 16;

	typedef struct packed {
		logic         ok;
		value_t       taken;
		value_t       head;
		value_t       tail;
		logic         empty;
		logic [4:0]   count;
	} queue_view_t;

	logic clk = 1'b0;
	logic arst_n;

	fqrv_cmd_if cmd_ch ();
	fqrv_rsp_if rsp_ch ();

	fifo_queue_remove_by_value_core #(
		.DEPTH (QUEUE_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.rsp_ch (rsp_ch)
	);

	value_t      held_values[$];
	queue_view_t pending_results[$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int commands_sent;
	int results_checked;
	int full_rejects;
	int empty_rejects;
	int remove_hits;
	int remove_misses;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		arst_n          = 1'b0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.cmd      = CMD_QUERY;
		cmd_ch.value_in = '0;
		rsp_ch.ready    = 1'b0;
	end

	// queue state after one command, as the block must report it
	function automatic queue_view_t apply_command(input logic [1:0] op, input value_t v);
		queue_view_t r;
		int hit;
		r = '0;
		hit = -1;
		case (op)
			CMD_QUERY: begin
				r.ok = 1'b1;
			end
			CMD_ENQUEUE: begin
				if (held_values.size() < QUEUE_DEPTH) begin
					held_values.push_back(v);
					r.ok = 1'b1;
				end else begin
					full_rejects++;
				end
			end
			CMD_DEQUEUE: begin
				if (held_values.size() > 0) begin
					r.taken = held_values.pop_front();
					r.ok = 1'b1;
				end else begin
					empty_rejects++;
				end
			end
			default: begin
				foreach (held_values[i])
					if (hit < 0 && held_values[i] == v) hit = i;
				if (hit >= 0) begin
					held_values.delete(hit);
					r.ok = 1'b1;
					remove_hits++;
				end else begin
					remove_misses++;
				end
			end
		endcase
		if (held_values.size() > 0) begin
			r.head = held_values[0];
			r.tail = held_values[held_values.size()-1];
		end
		r.empty = (held_values.size() == 0);
		r.count = 5'(held_values.size());
		return r;
	endfunction

	// one command transaction; valid stays high afterwards until the next call or a flush
	task automatic send_command(input logic [1:0] op, input value_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.cmd      <= op;
		cmd_ch.value_in <= v;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_results.push_back(apply_command(op, v));
		commands_sent++;
	endtask

	task automatic flush_commands();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		queue_view_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no command outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("ok", want.ok, rsp_ch.ok);
				check_field("out_value", want.taken, rsp_ch.out_value);
				check_field("head_value", want.head, rsp_ch.head_value);
				check_field("tail_value", want.tail, rsp_ch.tail_value);
				check_field("is_empty", want.empty, rsp_ch.is_empty);
				check_field("entry_count", want.count, rsp_ch.entry_count);
				results_checked++;
			end
		end
	end

	function automatic value_t pick_value();
		case ($urandom_range(3))
			0: return $urandom_range(6) - 3;
			1: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_command(CMD_QUERY, 32'sd0);
		send_command(CMD_DEQUEUE, 32'sh7fff_ffff);
		send_command(CMD_REMOVE, 32'sd0);
		send_command(CMD_ENQUEUE, 32'sh8000_0000);
		send_command(CMD_ENQUEUE, 32'sh7fff_ffff);
		send_command(CMD_ENQUEUE, 32'sd5);
		send_command(CMD_ENQUEUE, 32'sd5);
		// duplicate match, the one nearest the head must go
		send_command(CMD_REMOVE, 32'sd5);
		send_command(CMD_REMOVE, 32'sd99);
		send_command(CMD_DEQUEUE, 32'sh5555_5555);
		for (int i = 0; i < 14; i++)
			send_command(CMD_ENQUEUE, (i % 2) ? 32'shaaaa_aaaa : value_t'(i - 7));
		send_command(CMD_ENQUEUE, 32'sh1234_5678);
		send_command(CMD_REMOVE, 32'shaaaa_aaaa);
		flush_commands();
	endtask

	// random traffic in stretches that lean toward filling or draining the queue
	task automatic run_traffic(input int n_ops);
		int lean;
		int roll;
		logic [1:0] op;
		value_t v;
		lean = 1;
		for (int i = 0; i < n_ops; i++) begin
			if (i % 40 == 0) lean = $urandom_range(2);
			roll = $urandom_range(99);
			case (lean)
				0: op = (roll < 20) ? CMD_ENQUEUE : (roll < 55) ? CMD_DEQUEUE :
					(roll < 90) ? CMD_REMOVE : CMD_QUERY;
				1: op = (roll < 35) ? CMD_ENQUEUE : (roll < 60) ? CMD_DEQUEUE :
					(roll < 90) ? CMD_REMOVE : CMD_QUERY;
				default: op = (roll < 65) ? CMD_ENQUEUE : (roll < 78) ? CMD_DEQUEUE :
					(roll < 92) ? CMD_REMOVE : CMD_QUERY;
			endcase
			if (op == CMD_REMOVE && held_values.size() > 0 && $urandom_range(99) < 60)
				v = held_values[$urandom_range(held_values.size()-1)];
			else if (op == CMD_ENQUEUE || op == CMD_REMOVE)
				v = pick_value();
			else
				v = $urandom;
			send_command(op, v);
		end
		flush_commands();
	endtask

	task automatic test_no_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_traffic(300);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct  = 74;
		recv_stall_pct = 0;
		run_traffic(300);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct  = 0;
		recv_stall_pct = 74;
		run_traffic(300);
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 11;
		recv_stall_pct = 11;
		run_traffic(300);
	endtask

	initial begin
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		repeat (4) @(posedge clk);
		$display("%0d commands, %0d results checked, %0d mismatches",
			commands_sent, results_checked, mismatches);
		$display("enqueue on full %0d, dequeue on empty %0d, removes hit %0d / missed %0d",
			full_rejects, empty_rejects, remove_hits, remove_misses);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** fifo_queue_remove_by_value_core: PASSED **");
		end else begin
			$display("** fifo_queue_remove_by_value_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("** fifo_queue_remove_by_value_core: FAILED **");
		$finish;
	end

endmodule

[fifo_queue_remove_by_value_core.f]
rtl/fqrv_pkg.sv
rtl/fqrv_cmd_if.sv
rtl/fqrv_rsp_if.sv
rtl/fqrv_cell.sv
rtl/fifo_queue_remove_by_value_core.sv
tb/testbench.sv
